@@ rtl/core/spq_pkg.sv @@
// Shared types and constants for the stable priority queue.
// No dependencies; imported by every module of the block.
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int WORD_W      = 16;
  localparam int REC_W       = 4 * WORD_W;
  localparam int PRIO_W      = 8;
  localparam int OCC_W       = 5;
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 80;
  localparam int OUT_USER_W  = 3;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // What the datapath does with the accepted transaction
  typedef enum logic [1:0] {
    ACT_INSERT     = 2'd0,
    ACT_REMOVE     = 2'd1,
    ACT_DROP_FULL  = 2'd2,
    ACT_NONE_EMPTY = 2'd3
  } action_t;

  typedef struct packed {
    logic    exec;
    action_t action;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

@@ rtl/core/spq_ctrl.sv @@
// Controller: handshake state machine and action decode.
// Depends on spq_pkg.
module spq_ctrl import spq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  logic     s_tuser,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  dp_stat_t dp_stat,
  output dp_cmd_t  dp_cmd
);

  typedef enum logic [1:0] {
    ST_OUT_FREE = 2'b01,
    ST_OUT_HELD = 2'b10
  } state_t;

  state_t state, state_next;
  logic   accept;

  // output register may be reloaded in the cycle it is taken
  assign s_tready = (state == ST_OUT_FREE) || m_tready;
  assign m_tvalid = (state == ST_OUT_HELD);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    dp_cmd.exec = accept;
    if (opcode_t'(s_tuser) == OP_INSERT) begin
      dp_cmd.action = dp_stat.full ? ACT_DROP_FULL : ACT_INSERT;
    end else begin
      dp_cmd.action = dp_stat.empty ? ACT_NONE_EMPTY : ACT_REMOVE;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_OUT_FREE: begin
        if (accept) state_next = ST_OUT_HELD;
      end
      ST_OUT_HELD: begin
        if (m_tready && !accept) state_next = ST_OUT_FREE;
      end
      default: state_next = ST_OUT_FREE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_OUT_FREE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/core/spq_datapath.sv @@
// Datapath: sorted shift-register cells, record count and result register.
// Depends on spq_pkg.
module spq_datapath import spq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                dp_cmd,
  output dp_stat_t               dp_stat,
  input  logic [IN_DATA_W-1:0]   in_data,
  output logic [OUT_DATA_W-1:0]  out_data,
  output logic [OUT_USER_W-1:0]  out_user
);

  logic [REC_W-1:0]  rec   [QUEUE_DEPTH];
  logic [PRIO_W-1:0] pri   [QUEUE_DEPTH];
  logic [REC_W-1:0]  rec_next [QUEUE_DEPTH];
  logic [PRIO_W-1:0] pri_next [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] take;
  logic [CNT_W-1:0]  count;

  logic [REC_W-1:0]  new_rec;
  logic [PRIO_W-1:0] new_pri;

  logic [REC_W-1:0]  res_rec;
  logic [PRIO_W-1:0] res_pri;
  logic              res_valid;
  status_t           res_status;

  assign new_rec = in_data[REC_W-1:0];
  assign new_pri = in_data[REC_W +: PRIO_W];

  assign dp_stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign dp_stat.empty = (count == '0);

  // take[k]: new record belongs at or before cell k; monotone over k
  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      take[k] = (CNT_W'(k) >= count) || (new_pri < pri[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      rec_next[k] = rec[k];
      pri_next[k] = pri[k];
    end
    unique case (dp_cmd.action)
      ACT_INSERT: begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
          if (k > 0 && take[(k > 0) ? k - 1 : 0]) begin
            rec_next[k] = rec[(k > 0) ? k - 1 : 0];
            pri_next[k] = pri[(k > 0) ? k - 1 : 0];
          end else if (take[k]) begin
            rec_next[k] = new_rec;
            pri_next[k] = new_pri;
          end
        end
      end
      ACT_REMOVE: begin
        for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
          rec_next[k] = rec[k + 1];
          pri_next[k] = pri[k + 1];
        end
      end
      ACT_DROP_FULL, ACT_NONE_EMPTY: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
        rec[k] <= rec_next[k];
        pri[k] <= pri_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (dp_cmd.exec) begin
      if (dp_cmd.action == ACT_INSERT) begin
        count <= count + CNT_W'(1);
      end else if (dp_cmd.action == ACT_REMOVE) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // result register, loaded with every accepted transaction
  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      res_valid  <= (dp_cmd.action == ACT_REMOVE);
      res_rec    <= (dp_cmd.action == ACT_REMOVE) ? rec[0] : '0;
      res_pri    <= (dp_cmd.action == ACT_REMOVE) ? pri[0] : '0;
      unique case (dp_cmd.action)
        ACT_DROP_FULL:  res_status <= STAT_FULL;
        ACT_NONE_EMPTY: res_status <= STAT_EMPTY;
        ACT_INSERT, ACT_REMOVE: res_status <= STAT_DONE;
        default:        res_status <= STAT_DONE;
      endcase
    end
  end

  logic [CNT_W-1:0] count_shown;
  logic [OCC_W-1:0] occ;
  // occupancy is the count after the transaction, which is the live count
  assign count_shown = count;
  assign occ = (CNT_W >= OCC_W) ? OCC_W'(count_shown[CNT_W-1:0])
                                : OCC_W'(count_shown);

  assign out_data = {3'b000, occ, res_pri, res_rec};
  assign out_user = {res_status, res_valid};

endmodule

@@ rtl/core/stable_priority_queue.sv @@
// Top level of the stable priority queue: controller plus datapath.
// Depends on spq_pkg, spq_ctrl, spq_datapath.
//
//  channel | dir | tdata (low bit up)                         | tuser (low bit up)
//  s_*     | in  | word0, word1, word2, word3, priority       | opcode
//  m_*     | out | word0..word3, priority, occupancy, 3'b0   | out_valid, status
//
// One transaction per cycle: insert and remove each complete in the cycle of
// acceptance, all cells comparing against the new priority in parallel.
// The output register is reloaded in the cycle its result is taken, so a stall
// on m_* holds s_tready low only while a result waits and m_tready is low.
// rst is synchronous: the queue is empty afterwards; stored records need no reset.
module stable_priority_queue import spq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // word0, word1, word2, word3, priority
  input  logic                  s_tuser,   // opcode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // word0..word3, priority, occupancy, pad
  output logic [OUT_USER_W-1:0] m_tuser    // out_valid, status
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .dp_stat  (dp_stat),
    .dp_cmd   (dp_cmd)
  );

  spq_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat),
    .in_data  (s_tdata),
    .out_data (m_tdata),
    .out_user (m_tuser)
  );

endmodule

@@ rtl/core/spq_checker.sv @@
// Port-level checks for stable_priority_queue, bound to the top level.
// Depends on spq_pkg.
module spq_checker import spq_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [OUT_USER_W-1:0] m_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a presented record always reports done
  a_valid_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tuser[2:1] == STAT_DONE)
    else $error("record presented with error status");

  // empty remove leaves an empty queue and no record
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2:1] == STAT_EMPTY |-> !m_tuser[0] && m_tdata[76:72] == 5'd0)
    else $error("empty remove reported wrongly");

  // with no result pending the input side is always open
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with output free");

  // an accepted transaction always yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted transaction gave no result");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ dv/tb_stable_priority_queue.sv @@
// Self-checking bench for stable_priority_queue: directed fill, overflow, partial
// drain, then random insert/remove traffic under varying stalls on both streams.
// Depends on spq_pkg and the stable_priority_queue RTL only.
module tb_stable_priority_queue;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    logic              removed;
    logic [REC_W-1:0]  rec;
    logic [PRIO_W-1:0] prio;
    status_t           status;
    logic [OCC_W-1:0]  occ;
  } queue_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // word0, word1, word2, word3, priority
  logic                  s_tuser = 1'b0; // opcode
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // word0..word3, priority, occupancy, pad
  logic [OUT_USER_W-1:0] m_tuser;        // out_valid, status

  // shadow of the sorted store
  logic [REC_W-1:0]  shadow_rec [QUEUE_DEPTH];
  logic [PRIO_W-1:0] shadow_prio [QUEUE_DEPTH];
  int                shadow_count = 0;

  queue_result_t pending_results[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_len = 0;
  int stall_done = 0;

  stable_priority_queue u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_stable_priority_queue failed");
      $finish;
    end
  end

  // Sorted insert after all lower-or-equal priorities; remove takes the head.
  task automatic predict_queue_op(input opcode_t op, input logic [REC_W-1:0] rec,
                                  input logic [PRIO_W-1:0] prio,
                                  output queue_result_t res);
    int pos;
    res = '{removed: 1'b0, rec: '0, prio: '0, status: STAT_DONE, occ: '0};
    if (op == OP_INSERT) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        pos = shadow_count;
        for (int k = 0; k < shadow_count; k++) begin
          if (prio < shadow_prio[k]) begin
            pos = k;
            break;
          end
        end
        for (int k = shadow_count; k > pos; k--) begin
          shadow_rec[k]  = shadow_rec[k-1];
          shadow_prio[k] = shadow_prio[k-1];
        end
        shadow_rec[pos]  = rec;
        shadow_prio[pos] = prio;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = STAT_EMPTY;
      end else begin
        res.removed = 1'b1;
        res.rec     = shadow_rec[0];
        res.prio    = shadow_prio[0];
        for (int k = 1; k < shadow_count; k++) begin
          shadow_rec[k-1]  = shadow_rec[k];
          shadow_prio[k-1] = shadow_prio[k];
        end
        shadow_count--;
      end
    end
    res.occ = OCC_W'(shadow_count);
  endtask

  function automatic void check_field(input string field, input longint unsigned exp_v,
                                      input longint unsigned act_v);
    if (exp_v != act_v) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s: expected %0h, got %0h", field, exp_v, act_v);
    end
  endfunction

  task automatic check_result();
    queue_result_t exp_r;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result transaction: tdata %h tuser %h", m_tdata, m_tuser);
    end else begin
      exp_r = pending_results.pop_front();
      check_field("out_valid", exp_r.removed, m_tuser[0]);
      for (int k = 0; k < 4; k++)
        check_field($sformatf("out_word%0d", k), exp_r.rec[WORD_W*k +: WORD_W],
                    m_tdata[WORD_W*k +: WORD_W]);
      check_field("out_priority", exp_r.prio, m_tdata[REC_W +: PRIO_W]);
      check_field("status", exp_r.status, m_tuser[2:1]);
      check_field("occupancy", exp_r.occ, m_tdata[REC_W+PRIO_W +: OCC_W]);
    end
  endtask

  // Result side: random back-pressure, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (stall_len != 0 && stall_done < stall_len) begin
      m_tready   <= 1'b0;
      stall_done <= stall_done + 1;
    end else begin
      if (stall_len == 0)
        stall_done <= 0;
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
    if (!rst && m_tvalid && m_tready)
      check_result();
  end

  task automatic offer_op(input opcode_t op, input logic [REC_W-1:0] rec,
                          input logic [PRIO_W-1:0] prio);
    queue_result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {prio, rec};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_queue_op(op, rec, prio, res);
    pending_results.push_back(res);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [REC_W-1:0] random_record();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly a narrow range so that ties are common
  function automatic logic [PRIO_W-1:0] random_priority();
    case ($urandom_range(9))
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return PRIO_W'($urandom_range(7));
      default:    return PRIO_W'($urandom);
    endcase
  endfunction

  task automatic test_remove_empty();
    offer_op(OP_REMOVE, '1, '1);
  endtask

  // Fill with extreme words and repeated priorities, overflow once, take a few
  task automatic test_fill_and_overflow();
    logic [PRIO_W-1:0] prio_seq [QUEUE_DEPTH];
    logic [REC_W-1:0]  rec;
    prio_seq = '{8'd255, 8'd0, 8'd128, 8'd128, 8'd128, 8'd7, 8'd7, 8'd0,
                 8'd255, 8'd64, 8'd1, 8'd254, 8'd128, 8'd3, 8'd0, 8'd255};
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      rec = (k == 0) ? '0 : (k == 1) ? '1 : {$urandom, $urandom};
      offer_op(OP_INSERT, rec, prio_seq[k]);
    end
    offer_op(OP_INSERT, '1, '0);
    repeat (3) offer_op(OP_REMOVE, '0, '0);
  endtask

  task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
    int sent;
    int ins_pct;
    int burst;
    opcode_t op;
    sent = 0;
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    while (sent < n_items) begin
      // bursts biased toward filling, draining or balance
      case ($urandom_range(2))
        0:       ins_pct = 15;
        1:       ins_pct = 50;
        default: ins_pct = 85;
      endcase
      burst = $urandom_range(10, 40);
      for (int i = 0; i < burst && sent < n_items; i++) begin
        op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
        offer_op(op, random_record(), random_priority());
        sent++;
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering, so s_tready drops
  task automatic test_output_stall();
    tx_idle_pct = 0;
    stall_len <= 120;
    for (int i = 0; i < 30; i++)
      offer_op((i % 3 == 2) ? OP_REMOVE : OP_INSERT, random_record(), random_priority());
    while (stall_done < 120) @(posedge clk);
    stall_len <= 0;
  endtask

  task automatic test_sender_pause();
    tx_idle_pct = 0;
    rx_idle_pct <= 50;
    for (int i = 0; i < 10; i++)
      offer_op(OP_INSERT, random_record(), random_priority());
    wait_drained();
    for (int i = 0; i < 10; i++)
      offer_op(OP_REMOVE, random_record(), random_priority());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_remove_empty();
    test_fill_and_overflow();
    test_output_stall();
    test_sender_pause();
    test_random_traffic(160, 21, 80);
    test_random_traffic(160, 80, 21);
    test_random_traffic(160, 0, 0);
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_stable_priority_queue passed");
    end else begin
      $display("tb_stable_priority_queue failed");
    end
    $finish;
  end

endmodule
